FILE: design/bbt_pkg.sv
// Shared constants, field layout and axis codes of the bounding box transform.
package bbt_pkg;

  localparam int unsigned FRAC_BITS_DEF    = 29;
  localparam int unsigned SCALAR_WIDTH_DEF = 32;

  localparam int unsigned AXIS_W   = 2;
  localparam int unsigned COEF_W   = 32;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned NUM_COLS = 3;

  // Input beat layout, lowest bit first.
  localparam int unsigned AXIS_LSB    = 0;
  localparam int unsigned COEF_LSB    = AXIS_LSB + AXIS_W;
  localparam int unsigned OFFSET_LSB  = COEF_LSB + NUM_COLS * COEF_W;
  localparam int unsigned BMIN_LSB    = OFFSET_LSB + FIELD_W;
  localparam int unsigned BMAX_LSB    = BMIN_LSB + NUM_COLS * FIELD_W;
  localparam int unsigned S_DATA_BITS = BMAX_LSB + NUM_COLS * FIELD_W;
  localparam int unsigned S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;

  // Output beat layout, lowest bit first.
  localparam int unsigned WMIN_LSB    = AXIS_W;
  localparam int unsigned WMAX_LSB    = WMIN_LSB + FIELD_W;
  localparam int unsigned M_DATA_BITS = WMAX_LSB + FIELD_W;
  localparam int unsigned M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;

  localparam int unsigned PIPE_DEPTH = 4;
  localparam int unsigned OCC_W      = $clog2(PIPE_DEPTH + 1);

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

endpackage

FILE: design/bounding_box_transform.sv
// Top level of the bounding box transform: beat unpacking and the four-stage pipeline.
//
//   Channel   Dir  tdata (lowest bit first)                                tuser
//   s_axis    in   axis, coef_x/y/z, offset, box_min_x/y/z, box_max_x/y/z  rotate_mode
//   m_axis    out  axis_out, world_min, world_max                          overflow
//
// An accepted beat passes the stage-one, stage-two and stage-three registers in order
// and then the output register, from which it leaves on the m_axis channel.
// One beat per cycle is sustained while the output is not stalled.
// Each stage holds its own valid bit and takes a new beat when it is empty or
// its successor takes its beat, so bubbles close up while the output stalls.
// Reset clears the valid bits and the occupancy counter; the data registers are not reset.
module bounding_box_transform import bbt_pkg::*; #(
  parameter int unsigned FRAC_BITS    = FRAC_BITS_DEF,
  parameter int unsigned SCALAR_WIDTH = SCALAR_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // axis, coef_x, coef_y, coef_z, offset, box_min_x, box_min_y, box_min_z,
  // box_max_x, box_max_y, box_max_z, zero fill
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // rotate_mode
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // axis_out, world_min, world_max, zero fill
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // overflow
  output logic                 m_axis_tuser
);

  localparam int unsigned SW = SCALAR_WIDTH;
  localparam int unsigned PW = COEF_W + SW;

  logic [NUM_COLS-1:0][COEF_W-1:0] coef;
  logic [NUM_COLS-1:0][SW-1:0]     bmin, bmax;
  logic [SW-1:0]                   off_in;

  always_comb begin
    for (int j = 0; j < NUM_COLS; j++) begin
      coef[j] = s_axis_tdata[COEF_LSB + j*COEF_W +: COEF_W];
      bmin[j] = s_axis_tdata[BMIN_LSB + j*FIELD_W +: SW];
      bmax[j] = s_axis_tdata[BMAX_LSB + j*FIELD_W +: SW];
    end
  end
  assign off_in = s_axis_tdata[OFFSET_LSB +: SW];

  logic                        m1_valid, m1_ready;
  logic [NUM_COLS-1:0][PW-1:0] m1_pmin, m1_pmax;
  logic [SW-1:0]               m1_off, m1_cmin, m1_cmax;
  logic [AXIS_W-1:0]           m1_axis;
  logic                        m1_rot;

  bbt_mul #(.SW(SW)) u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .coef_i     (coef),
    .bmin_i     (bmin),
    .bmax_i     (bmax),
    .off_i      (off_in),
    .axis_i     (s_axis_tdata[AXIS_LSB +: AXIS_W]),
    .rot_i      (s_axis_tuser),
    .valid_o    (m1_valid),
    .ready_i    (m1_ready),
    .prod_min_o (m1_pmin),
    .prod_max_o (m1_pmax),
    .off_o      (m1_off),
    .cmin_o     (m1_cmin),
    .cmax_o     (m1_cmax),
    .axis_o     (m1_axis),
    .rot_o      (m1_rot)
  );

  logic                        o2_valid, o2_ready;
  logic [NUM_COLS-1:0][SW-1:0] o2_lo, o2_hi;
  logic [SW-1:0]               o2_off;
  logic [AXIS_W-1:0]           o2_axis;
  logic                        o2_ovf;

  bbt_order #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_order (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (m1_valid),
    .ready_o    (m1_ready),
    .prod_min_i (m1_pmin),
    .prod_max_i (m1_pmax),
    .off_i      (m1_off),
    .cmin_i     (m1_cmin),
    .cmax_i     (m1_cmax),
    .axis_i     (m1_axis),
    .rot_i      (m1_rot),
    .valid_o    (o2_valid),
    .ready_i    (o2_ready),
    .lo_o       (o2_lo),
    .hi_o       (o2_hi),
    .off_o      (o2_off),
    .axis_o     (o2_axis),
    .ovf_o      (o2_ovf)
  );

  logic [AXIS_W-1:0]  out_axis;
  logic [FIELD_W-1:0] out_min, out_max;

  bbt_accum #(.SW(SW)) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (o2_valid),
    .ready_o     (o2_ready),
    .lo_i        (o2_lo),
    .hi_i        (o2_hi),
    .off_i       (o2_off),
    .axis_i      (o2_axis),
    .ovf_i       (o2_ovf),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .axis_o      (out_axis),
    .world_min_o (out_min),
    .world_max_o (out_max),
    .ovf_o       (m_axis_tuser)
  );

  assign m_axis_tdata = {{(M_TDATA_W-M_DATA_BITS){1'b0}}, out_max, out_min, out_axis};

  // Beats held inside the pipeline.
  logic [OCC_W-1:0] occ_d, occ_q;
  logic             in_beat, out_beat;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign occ_d    = occ_q + OCC_W'(in_beat) - OCC_W'(out_beat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(PIPE_DEPTH))
    else $error("more beats in flight than pipeline stages");

  a_empty_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == '0 |-> !m_axis_tvalid)
    else $error("output beat with an empty pipeline");

  a_no_stall_empty_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output register is empty");

endmodule

FILE: design/bbt_mul.sv
// Stage one: six column products and the translate-mode component select.
module bbt_mul import bbt_pkg::*; #(
  parameter int unsigned SW = SCALAR_WIDTH_DEF,
  localparam int unsigned PW = COEF_W + SW
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic [NUM_COLS-1:0][COEF_W-1:0]  coef_i,
  input  logic [NUM_COLS-1:0][SW-1:0]      bmin_i,
  input  logic [NUM_COLS-1:0][SW-1:0]      bmax_i,
  input  logic [SW-1:0]                    off_i,
  input  logic [AXIS_W-1:0]                axis_i,
  input  logic                             rot_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic [NUM_COLS-1:0][PW-1:0]      prod_min_o,
  output logic [NUM_COLS-1:0][PW-1:0]      prod_max_o,
  output logic [SW-1:0]                    off_o,
  output logic [SW-1:0]                    cmin_o,
  output logic [SW-1:0]                    cmax_o,
  output logic [AXIS_W-1:0]                axis_o,
  output logic                             rot_o
);

  logic                        valid_q;
  logic                        load;
  logic [NUM_COLS-1:0][PW-1:0] prod_min_d, prod_max_d, prod_min_q, prod_max_q;
  logic [SW-1:0]               cmin_d, cmax_d, cmin_q, cmax_q, off_q;
  logic [AXIS_W-1:0]           axis_q;
  logic                        rot_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    for (int j = 0; j < NUM_COLS; j++) begin
      prod_min_d[j] = $signed(coef_i[j]) * $signed(bmin_i[j]);
      prod_max_d[j] = $signed(coef_i[j]) * $signed(bmax_i[j]);
    end
  end

  always_comb begin
    case (axis_e'(axis_i))
      AXIS_X: begin
        cmin_d = bmin_i[0];
        cmax_d = bmax_i[0];
      end
      AXIS_Y: begin
        cmin_d = bmin_i[1];
        cmax_d = bmax_i[1];
      end
      AXIS_Z: begin
        cmin_d = bmin_i[2];
        cmax_d = bmax_i[2];
      end
      default: begin
        cmin_d = '0;
        cmax_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      prod_min_q <= prod_min_d;
      prod_max_q <= prod_max_d;
      cmin_q     <= cmin_d;
      cmax_q     <= cmax_d;
      off_q      <= off_i;
      axis_q     <= axis_i;
      rot_q      <= rot_i;
    end
  end

  assign valid_o    = valid_q;
  assign prod_min_o = prod_min_q;
  assign prod_max_o = prod_max_q;
  assign cmin_o     = cmin_q;
  assign cmax_o     = cmax_q;
  assign off_o      = off_q;
  assign axis_o     = axis_q;
  assign rot_o      = rot_q;

endmodule

FILE: design/bbt_order.sv
// Stage two: fixed-point scaling, wrap check and min/max ordering per column.
module bbt_order import bbt_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned SW        = SCALAR_WIDTH_DEF,
  localparam int unsigned PW = COEF_W + SW,
  localparam int unsigned QW = PW - FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [NUM_COLS-1:0][PW-1:0]  prod_min_i,
  input  logic [NUM_COLS-1:0][PW-1:0]  prod_max_i,
  input  logic [SW-1:0]                off_i,
  input  logic [SW-1:0]                cmin_i,
  input  logic [SW-1:0]                cmax_i,
  input  logic [AXIS_W-1:0]            axis_i,
  input  logic                         rot_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [NUM_COLS-1:0][SW-1:0]  lo_o,
  output logic [NUM_COLS-1:0][SW-1:0]  hi_o,
  output logic [SW-1:0]                off_o,
  output logic [AXIS_W-1:0]            axis_o,
  output logic                         ovf_o
);

  logic                        valid_q;
  logic                        load;
  logic [NUM_COLS-1:0][SW-1:0] lo_d, hi_d, lo_q, hi_q;
  logic                        ovf_d, ovf_q;
  logic [SW-1:0]               off_q;
  logic [AXIS_W-1:0]           axis_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // The arithmetic shift of the exact product floors toward minus infinity.
  always_comb begin
    logic [QW-1:0] qa, qb;
    logic [SW-1:0] wa, wb;
    lo_d  = '0;
    hi_d  = '0;
    ovf_d = 1'b0;
    for (int j = 0; j < NUM_COLS; j++) begin
      qa = prod_min_i[j][PW-1:FRAC_BITS];
      qb = prod_max_i[j][PW-1:FRAC_BITS];
      wa = qa[SW-1:0];
      wb = qb[SW-1:0];
      if (qa[QW-1:SW-1] != {(QW-SW+1){qa[SW-1]}}) ovf_d = 1'b1;
      if (qb[QW-1:SW-1] != {(QW-SW+1){qb[SW-1]}}) ovf_d = 1'b1;
      if ($signed(wa) < $signed(wb)) begin
        lo_d[j] = wa;
        hi_d[j] = wb;
      end else begin
        lo_d[j] = wb;
        hi_d[j] = wa;
      end
    end
    if (!rot_i) begin
      lo_d    = '0;
      hi_d    = '0;
      lo_d[0] = cmin_i;
      hi_d[0] = cmax_i;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      ovf_q  <= ovf_d;
      off_q  <= off_i;
      axis_q <= axis_i;
    end
  end

  assign valid_o = valid_q;
  assign lo_o    = lo_q;
  assign hi_o    = hi_q;
  assign ovf_o   = ovf_q;
  assign off_o   = off_q;
  assign axis_o  = axis_q;

endmodule

FILE: design/bbt_accum.sv
// Stages three and four: wrapping accumulation of the ordered column terms.
module bbt_accum import bbt_pkg::*; #(
  parameter int unsigned SW = SCALAR_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [NUM_COLS-1:0][SW-1:0]  lo_i,
  input  logic [NUM_COLS-1:0][SW-1:0]  hi_i,
  input  logic [SW-1:0]                off_i,
  input  logic [AXIS_W-1:0]            axis_i,
  input  logic                         ovf_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [AXIS_W-1:0]            axis_o,
  output logic [FIELD_W-1:0]           world_min_o,
  output logic [FIELD_W-1:0]           world_max_o,
  output logic                         ovf_o
);

  // Returns the wrapped sum with the wrap flag on top.
  function automatic logic [SW:0] add_wrap(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] s;
    s = {a[SW-1], a} + {b[SW-1], b};
    return {s[SW] ^ s[SW-1], s[SW-1:0]};
  endfunction

  logic              va_q, vb_q;
  logic              ready_b;
  logic              load_a, load_b;
  logic [SW:0]       lo_s0, lo_s1, hi_s0, hi_s1, lo_s2, hi_s2;
  logic [SW-1:0]     lo_a_q, hi_a_q, lo2_q, hi2_q;
  logic              ovf_a_d, ovf_a_q, ovf_b_d, ovf_b_q;
  logic [AXIS_W-1:0] axis_a_q, axis_b_q;
  logic [FIELD_W-1:0] wmin_q, wmax_q;

  assign ready_b = !vb_q || ready_i;
  assign ready_o = !va_q || ready_b;
  assign load_a  = valid_i && ready_o;
  assign load_b  = va_q && ready_b;

  assign lo_s0   = add_wrap(off_i, lo_i[0]);
  assign lo_s1   = add_wrap(lo_s0[SW-1:0], lo_i[1]);
  assign hi_s0   = add_wrap(off_i, hi_i[0]);
  assign hi_s1   = add_wrap(hi_s0[SW-1:0], hi_i[1]);
  assign ovf_a_d = ovf_i | lo_s0[SW] | lo_s1[SW] | hi_s0[SW] | hi_s1[SW];

  assign lo_s2   = add_wrap(lo_a_q, lo2_q);
  assign hi_s2   = add_wrap(hi_a_q, hi2_q);
  assign ovf_b_d = ovf_a_q | lo_s2[SW] | hi_s2[SW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_o) begin
        va_q <= valid_i;
      end
      if (ready_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_a) begin
      lo_a_q   <= lo_s1[SW-1:0];
      hi_a_q   <= hi_s1[SW-1:0];
      lo2_q    <= lo_i[2];
      hi2_q    <= hi_i[2];
      ovf_a_q  <= ovf_a_d;
      axis_a_q <= axis_i;
    end
    if (load_b) begin
      wmin_q   <= FIELD_W'($signed(lo_s2[SW-1:0]));
      wmax_q   <= FIELD_W'($signed(hi_s2[SW-1:0]));
      ovf_b_q  <= ovf_b_d;
      axis_b_q <= axis_a_q;
    end
  end

  assign valid_o     = vb_q;
  assign axis_o      = axis_b_q;
  assign world_min_o = wmin_q;
  assign world_max_o = wmax_q;
  assign ovf_o       = ovf_b_q;

endmodule
